>>> rtl/ll1atp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ll1atp_pkg: symbols and rule tables for the assembly token parser
// Encodes stack symbols, result status codes, the rule selection per
// sub-state and the fixed pattern bodies pushed on expansion.
// ----------------------------------------------------------------------------
package ll1atp_pkg;

    typedef logic [5:0] sym_t;
    typedef logic [4:0] token_t;

    localparam int PAT_MAX = 5;

    typedef logic [PAT_MAX-1:0][5:0] pat_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] rule;
    } rule_sel_t;

    // Status codes
    localparam logic [1:0] ST_PARSING  = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_NO_RULE  = 2'd3;

    // Token codes that the rules look at
    localparam token_t T_REG      = 5'd0;
    localparam token_t T_IMM      = 5'd1;
    localparam token_t T_LAB      = 5'd2;
    localparam token_t T_COLON    = 5'd3;
    localparam token_t T_AND      = 5'd4;
    localparam token_t T_ORR      = 5'd5;
    localparam token_t T_XOR      = 5'd6;
    localparam token_t T_ADD      = 5'd7;
    localparam token_t T_SUB      = 5'd8;
    localparam token_t T_SHL      = 5'd9;
    localparam token_t T_SHR      = 5'd10;
    localparam token_t T_LBI      = 5'd11;
    localparam token_t T_BRC      = 5'd12;
    localparam token_t T_LDR      = 5'd13;
    localparam token_t T_STR      = 5'd14;
    localparam token_t T_SWP      = 5'd15;
    localparam token_t T_JPR      = 5'd16;
    localparam token_t T_JLR      = 5'd17;
    localparam token_t T_NOP      = 5'd18;
    localparam token_t T_HLT      = 5'd19;
    localparam token_t T_LD       = 5'd20;
    localparam token_t T_ST       = 5'd21;
    localparam token_t T_DS       = 5'd22;
    localparam token_t T_TO       = 5'd23;
    localparam token_t T_WORD     = 5'd24;
    localparam token_t T_ARRY     = 5'd25;
    localparam token_t T_ADDR     = 5'd26;
    localparam token_t T_EOF      = 5'd27;
    localparam token_t T_FLAG     = 5'd28;
    localparam token_t T_STRING   = 5'd29;
    localparam token_t T_QUESTION = 5'd30;

    // Stack symbols: tokens 0..30, actions 32..47, sub-states 51..58
    localparam sym_t SYM_REG      = 6'd0;
    localparam sym_t SYM_IMM      = 6'd1;
    localparam sym_t SYM_LAB      = 6'd2;
    localparam sym_t SYM_COLON    = 6'd3;
    localparam sym_t SYM_ACT_BASE = 6'd32;
    localparam sym_t SYM_NONE     = 6'd63;

    localparam sym_t S_START      = 6'd51;
    localparam sym_t S_ALU_TAIL   = 6'd52;
    localparam sym_t S_SHIFT_TAIL = 6'd53;
    localparam sym_t S_FLAG_REG   = 6'd54;
    localparam sym_t S_FLAG_IMM   = 6'd55;
    localparam sym_t S_REG_LABEL  = 6'd56;
    localparam sym_t S_DATA       = 6'd57;
    localparam sym_t S_ADDR_VAL   = 6'd58;

    // Pattern numbers used by the sub-state rules
    localparam logic [4:0] R_EMPTY     = 5'd17;
    localparam logic [4:0] R_ACT_RRR   = 5'd18;
    localparam logic [4:0] R_ACT_RI5   = 5'd19;
    localparam logic [4:0] R_ACT_RRI4  = 5'd20;
    localparam logic [4:0] R_PUSH_REG  = 5'd21;
    localparam logic [4:0] R_PUSH_IMM  = 5'd22;
    localparam logic [4:0] R_PUSH_LAB  = 5'd23;

    function automatic logic is_token(input sym_t v);
        return (v[5] == 1'b0) && (v[4:0] != 5'h1f);
    endfunction

    function automatic logic is_action(input sym_t v);
        return v[5:4] == 2'b10;
    endfunction

    function automatic sym_t act(input int n);
        return SYM_ACT_BASE + sym_t'(n);
    endfunction

    // First entry lands lowest, so it is pushed first
    function automatic pat_t pat5(input sym_t a, input sym_t b, input sym_t c,
                                  input sym_t d, input sym_t e);
        return {e, d, c, b, a};
    endfunction

    function automatic logic [2:0] pat_len(input logic [4:0] rule);
        logic [2:0] len;
        unique case (rule)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd9, 5'd10: len = 3'd4;
            5'd5, 5'd7:                                len = 3'd5;
            5'd4, 5'd11, 5'd12, 5'd13, 5'd14,
            5'd15, 5'd16:                              len = 3'd3;
            5'd8:                                      len = 3'd2;
            5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23:  len = 3'd1;
            default:                                   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic pat_t pat_body(input logic [4:0] rule);
        pat_t p;
        unique case (rule)
            5'd0:  p = pat5(S_START, S_ALU_TAIL, SYM_REG, SYM_REG, '0);
            5'd1:  p = pat5(S_START, S_SHIFT_TAIL, SYM_REG, SYM_REG, '0);
            5'd2:  p = pat5(S_START, S_SHIFT_TAIL, SYM_REG, S_FLAG_REG, '0);
            5'd3:  p = pat5(S_START, act(0), SYM_IMM, S_FLAG_REG, '0);
            5'd4:  p = pat5(S_START, act(1), S_FLAG_IMM, '0, '0);
            5'd5:  p = pat5(S_START, act(2), SYM_IMM, SYM_REG, SYM_REG);
            5'd6:  p = pat5(S_START, act(3), SYM_IMM, SYM_REG, '0);
            5'd7:  p = pat5(S_START, act(4), SYM_IMM, SYM_REG, SYM_REG);
            5'd8:  p = pat5(S_START, act(5), '0, '0, '0);
            5'd9:  p = pat5(S_START, act(6), SYM_LAB, SYM_REG, '0);
            5'd10: p = pat5(S_START, act(7), SYM_LAB, SYM_REG, '0);
            5'd11: p = pat5(S_START, act(8), SYM_REG, '0, '0);
            5'd12: p = pat5(S_START, act(9), S_REG_LABEL, '0, '0);
            5'd13: p = pat5(S_START, act(10), SYM_IMM, '0, '0);
            5'd14: p = pat5(S_START, act(11), S_DATA, '0, '0);
            5'd15: p = pat5(S_START, act(12), S_ADDR_VAL, '0, '0);
            5'd16: p = pat5(S_START, act(13), SYM_COLON, '0, '0);
            5'd18: p = pat5(act(14), '0, '0, '0, '0);
            5'd19: p = pat5(act(4), '0, '0, '0, '0);
            5'd20: p = pat5(act(15), '0, '0, '0, '0);
            5'd21: p = pat5(SYM_REG, '0, '0, '0, '0);
            5'd22: p = pat5(SYM_IMM, '0, '0, '0, '0);
            5'd23: p = pat5(SYM_LAB, '0, '0, '0, '0);
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic rule_sel_t start_rule(input token_t tok);
        rule_sel_t s;
        s.hit = 1'b1;
        unique case (tok)
            T_LAB:                                s.rule = 5'd16;
            T_AND, T_ORR, T_XOR, T_ADD, T_SUB:   s.rule = 5'd0;
            T_SHL:                                s.rule = 5'd1;
            T_SHR:                                s.rule = 5'd2;
            T_LBI:                                s.rule = 5'd3;
            T_BRC:                                s.rule = 5'd4;
            T_LDR, T_STR, T_SWP:                  s.rule = 5'd5;
            T_JPR:                                s.rule = 5'd6;
            T_JLR:                                s.rule = 5'd7;
            T_NOP, T_HLT:                         s.rule = 5'd8;
            T_LD:                                 s.rule = 5'd9;
            T_ST:                                 s.rule = 5'd10;
            T_DS:                                 s.rule = 5'd11;
            T_TO:                                 s.rule = 5'd12;
            T_WORD:                               s.rule = 5'd13;
            T_ARRY:                               s.rule = 5'd14;
            T_ADDR:                               s.rule = 5'd15;
            T_EOF:                                s.rule = R_EMPTY;
            default: begin
                s.hit  = 1'b0;
                s.rule = '0;
            end
        endcase
        return s;
    endfunction

    function automatic rule_sel_t select_rule(input sym_t sub, input token_t tok);
        rule_sel_t s;
        s.hit  = 1'b0;
        s.rule = '0;
        unique case (sub)
            S_START: s = start_rule(tok);
            S_ALU_TAIL: begin
                if (tok == T_REG) s = '{hit: 1'b1, rule: R_ACT_RRR};
                if (tok == T_IMM) s = '{hit: 1'b1, rule: R_ACT_RI5};
            end
            S_SHIFT_TAIL: begin
                if (tok == T_REG) s = '{hit: 1'b1, rule: R_ACT_RRR};
                if (tok == T_IMM) s = '{hit: 1'b1, rule: R_ACT_RRI4};
            end
            S_FLAG_REG: begin
                if (tok == T_FLAG) s = '{hit: 1'b1, rule: R_PUSH_REG};
                if (tok == T_REG)  s = '{hit: 1'b1, rule: R_EMPTY};
            end
            S_FLAG_IMM: begin
                if (tok == T_FLAG) s = '{hit: 1'b1, rule: R_PUSH_IMM};
                if (tok == T_IMM)  s = '{hit: 1'b1, rule: R_EMPTY};
            end
            S_REG_LABEL: begin
                if (tok == T_REG) s = '{hit: 1'b1, rule: R_PUSH_LAB};
                if (tok == T_LAB) s = '{hit: 1'b1, rule: R_EMPTY};
            end
            S_DATA: begin
                if (tok == T_STRING || tok == T_IMM) s = '{hit: 1'b1, rule: R_EMPTY};
            end
            S_ADDR_VAL: begin
                if (tok == T_IMM || tok == T_QUESTION) s = '{hit: 1'b1, rule: R_EMPTY};
            end
            default: s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ll1_assembly_token_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ll1_assembly_token_parser: table-driven LL(1) recogniser for assembly tokens
//
//   channel  dir  tdata (low bit up)                     tuser
//   s_       in   token_code[4:0], zero pad [7:5]        restart
//   m_       out  status[1:0], action_valid, action_code[6:3], pad [7]
//
// One word per cycle unless m_ stalls: the stack top, rule table and pattern
// push are worked out in one combinational pass between the stack registers
// and the result register, and m_tvalid rises in the cycle after acceptance.
// aresetn (synchronous) leaves the start sub-state alone on the stack.
// A word is taken while the result register is empty or being drained, so
// a stall on m_ only holds s_tready low once a result is waiting.
// ----------------------------------------------------------------------------
module ll1_assembly_token_parser #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // token_code[4:0], zero [7:5]
    input  wire logic       s_tuser,   // restart
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // status[1:0], action_valid[2], action_code[6:3]
);
    import ll1atp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    // Actions sit only just above a start sub-state, so two levels suffice
    localparam int DISCARD_MAX = 2;

    sym_t             stack_reg [STACK_DEPTH];
    sym_t             stack_next[STACK_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             error_reg, error_next;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;

    token_t           token;
    logic             restart;
    logic             accept;

    logic [CNT_W-1:0] cnt_w;
    logic [CNT_W-1:0] base_w;
    logic [CNT_W-1:0] mid_w;
    logic [CNT_W:0]   end_w;
    sym_t             top_w;
    sym_t             top_after;
    rule_sel_t        sel_w;
    pat_t             pat_w;
    logic [2:0]       plen_w;
    logic             ok_w;
    logic [1:0]       status_w;
    logic             act_valid_w;
    logic [3:0]       act_code_w;

    assign token    = s_tdata[4:0];
    assign restart  = s_tuser;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        stack_next  = stack_reg;
        count_next  = count_reg;
        error_next  = error_reg;
        status_w    = ST_PARSING;
        act_valid_w = 1'b0;
        act_code_w  = '0;
        cnt_w       = count_reg;
        base_w      = '0;
        mid_w       = '0;
        end_w       = '0;
        top_w       = SYM_NONE;
        top_after   = SYM_NONE;
        sel_w       = '0;
        pat_w       = '0;
        plen_w      = '0;
        ok_w        = 1'b0;

        if (count_reg != '0) begin
            top_w = stack_reg[IDX_W'(count_reg - 1'b1)];
        end

        if (restart) begin
            stack_next[0] = S_START;
            count_next    = CNT_W'(1);
            error_next    = 1'b0;
        end else if (error_reg) begin
            // hold everything; report what is on top
            status_w = (count_reg != '0 && is_token(top_w)) ? ST_MISMATCH : ST_NO_RULE;
        end else begin
            // drop stale actions from the top
            for (int d = 0; d < DISCARD_MAX; d++) begin
                if (cnt_w != '0 && is_action(stack_reg[IDX_W'(cnt_w - 1'b1)])) begin
                    cnt_w = cnt_w - 1'b1;
                end
            end
            count_next = cnt_w;
            top_w      = (cnt_w != '0) ? stack_reg[IDX_W'(cnt_w - 1'b1)] : SYM_NONE;
            base_w     = cnt_w - 1'b1;
            sel_w      = select_rule(top_w, token);
            pat_w      = pat_body(sel_w.rule);
            plen_w     = pat_len(sel_w.rule);

            if (cnt_w == '0) begin
                error_next = 1'b1;
                status_w   = ST_NO_RULE;
            end else if (is_token(top_w)) begin
                if (top_w == {1'b0, token}) begin
                    mid_w = base_w;
                    ok_w  = 1'b1;
                end else begin
                    error_next = 1'b1;
                    status_w   = ST_MISMATCH;
                end
            end else if (!sel_w.hit) begin
                error_next = 1'b1;
                status_w   = ST_NO_RULE;
            end else begin
                // replace the sub-state by its pattern, clipped at STACK_DEPTH
                for (int j = 0; j < STACK_DEPTH; j++) begin
                    if (j >= int'(base_w) && (j - int'(base_w)) < int'(plen_w)) begin
                        stack_next[j] = pat_w[3'(j - int'(base_w))];
                    end
                end
                end_w = {1'b0, base_w} + (CNT_W + 1)'(plen_w);
                mid_w = (end_w > (CNT_W + 1)'(STACK_DEPTH)) ?
                        CNT_W'(STACK_DEPTH) : end_w[CNT_W-1:0];
                ok_w  = 1'b1;
            end

            if (ok_w) begin
                if (mid_w != '0) begin
                    top_after = stack_next[IDX_W'(mid_w - 1'b1)];
                end
                // pop and report an exposed action
                if (mid_w != '0 && is_action(top_after)) begin
                    act_valid_w = 1'b1;
                    act_code_w  = top_after[3:0];
                    mid_w       = mid_w - 1'b1;
                end
                status_w   = (mid_w == '0) ? ST_DONE : ST_PARSING;
                count_next = mid_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_reg[0] <= S_START;
            count_reg    <= CNT_W'(1);
            error_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                stack_reg    <= stack_next;
                count_reg    <= count_next;
                error_reg    <= error_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, act_code_w, act_valid_w, status_w};
        end
    end

endmodule
`default_nettype wire
